// ===== src/wfbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint filter / blend radius package
// Shared types, register indexes and widths for the waypoint filter core.
// ----------------------------------------------------------------------------
package wfbr_pkg;

  localparam int CoordWidthDef = 32;
  localparam int CountWidthDef = 16;
  localparam int DataWidthDef  = 4 * CoordWidthDef + 6;

  localparam int PosWidth      = 32;
  localparam int RadiusWidth   = 32;
  localparam int KeptCntWidth  = 16;
  localparam int SegWidth      = 16;
  localparam int NormWidth     = 32;
  localparam int SmoothWidth   = 17;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 32;
  localparam int DigitWidth    = 8;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CfgMinSegment   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgMinColinear  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSmoothness   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgSmoothFloor  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgSmoothCeil   = 3'd4;

  localparam logic [SegWidth-1:0]    MinSegmentRst = 16'd10;
  localparam logic [NormWidth-1:0]   MinColinearRst = 32'd1;
  localparam logic [SmoothWidth-1:0] SmoothnessRst = 17'd65536;
  localparam logic [SmoothWidth-1:0] SmoothFloorRst = 17'd0;
  localparam logic [SmoothWidth-1:0] SmoothCeilRst = 17'd65536;

  typedef enum logic [1:0] {
    ARITH_MAC  = 2'd0,
    ARITH_SQRT = 2'd1,
    ARITH_DIV  = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic      go;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic [PosWidth-1:0] pos_x;
    logic [PosWidth-1:0] pos_y;
    logic [PosWidth-1:0] pos_z;
    logic                is_start;
    logic                is_last;
  } item_t;

  typedef struct packed {
    logic                    kept;
    logic                    is_final;
    logic [RadiusWidth-1:0]  blend_radius;
    logic                    colinear_error;
    logic [KeptCntWidth-1:0] kept_count;
  } result_t;

endpackage

// ===== src/waypoint_filter_blend_radius_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint filter and blend radius core
// Drops waypoints not farther than the minimum segment from the last kept point,
// flags colinear junctions and tracks the smallest junction blend radius.
// ----------------------------------------------------------------------------
// A start pose skips the arithmetic; a dropped or plain kept point uses only
// multiply-accumulate steps; a full junction also takes three square roots
// and one divide on the shared arithmetic unit.
// Throughput: one transaction at a time; item_stall is high until done.
// Reset (rst, synchronous) clears the path state and restores register defaults.
module waypoint_filter_blend_radius_core #(
  parameter int COORD_WIDTH = wfbr_pkg::CoordWidthDef,
  parameter int COUNT_WIDTH = wfbr_pkg::CountWidthDef
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  wfbr_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output wfbr_pkg::result_t                     result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wfbr_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [wfbr_pkg::CfgDataWidth-1:0]     cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = 4 * CW + 6;   // arithmetic unit width
  localparam int DFW = CW + 1;       // coordinate difference
  localparam int SQW = 2 * CW + 4;   // squares, dot and cross terms
  localparam int QW  = 4 * CW + 4;   // squared cross norm
  localparam int MW  = CW + 2;       // root of shorter segment
  localparam int RW  = wfbr_pkg::RadiusWidth;

  localparam logic [RW-1:0] RadiusMax = {RW{1'b1}};

  // Sequencer: one-hot, at most one arithmetic step in flight (k walks x, y, z)
  typedef enum logic [21:0] {
    S_IDLE   = 22'h000001,
    S_LIMSEG = 22'h000002,
    S_DIFF   = 22'h000004,
    S_DSQ    = 22'h000008,
    S_KEEP   = 22'h000010,
    S_CROSS  = 22'h000020,
    S_CSQ    = 22'h000040,
    S_LIMCOL = 22'h000080,
    S_COLCHK = 22'h000100,
    S_AB     = 22'h000200,
    S_ABSQ   = 22'h000400,
    S_DOT    = 22'h000800,
    S_TN     = 22'h001000,
    S_CN     = 22'h002000,
    S_CNCHK  = 22'h004000,
    S_M      = 22'h008000,
    S_NUM    = 22'h010000,
    S_DIV    = 22'h020000,
    S_COMMIT = 22'h040000,
    S_FIN    = 22'h080000,
    S_FSCALE = 22'h100000,
    S_OUT    = 22'h200000
  } state_t;

  state_t state;
  logic [1:0] k, k1, k2;
  logic j, issued;

  // configuration
  logic [wfbr_pkg::SegWidth-1:0]    min_seg;
  logic [wfbr_pkg::NormWidth-1:0]   min_col;
  logic [wfbr_pkg::SmoothWidth-1:0] smooth, smooth_floor, smooth_ceil, s_lo, s_clamp;

  // path state
  logic [CW-1:0]          last_pt [3];
  logic [DFW-1:0]         a_vec   [3];
  logic [SQW-1:0]         d1;
  logic [COUNT_WIDTH-1:0] point_count;
  logic [RW-1:0]          min_radius;
  logic                   error_flag;

  // current transaction and scratch
  logic [CW-1:0]  p     [3];
  logic [CW-1:0]  item_p[3];
  logic           p_last, kept;
  logic [DFW-1:0] d_vec [3];
  logic [DFW-1:0] ne_vec[3];
  logic [SQW-1:0] c_vec [3];
  logic [SQW-1:0] dsq, ab, dot_ae, tn, cn;
  logic [QW-1:0]  csq;
  logic [MW-1:0]  m;
  logic [31:0]    lim_seg;
  logic [63:0]    lim_col;
  logic [RW-1:0]  fin_radius, div_radius;
  logic [32:0]    cnt_wide;

  wfbr_pkg::arith_req_t req;
  logic [DW-1:0] opa, opb, opc, res;
  logic          arith_done;
  wfbr_pkg::result_t out_reg;
  logic              out_valid;

  function automatic logic [DW-1:0] sx_diff(input logic [DFW-1:0] v);
    return {{(DW-DFW){v[DFW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] sx_coord(input logic [CW-1:0] v);
    return {{(DW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] sx_sq(input logic [SQW-1:0] v);
    return {{(DW-SQW){v[SQW-1]}}, v};
  endfunction

  function automatic logic [1:0] idx_inc(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  assign k1 = idx_inc(k);
  assign k2 = idx_inc(k1);

  // take the low COORD_WIDTH bits of each position field
  assign item_p[0] = CW'($unsigned(item.pos_x));
  assign item_p[1] = CW'($unsigned(item.pos_y));
  assign item_p[2] = CW'($unsigned(item.pos_z));

  // clamp smoothness: ceiling wins over floor when crossed
  assign s_lo    = (smooth < smooth_floor) ? smooth_floor : smooth;
  assign s_clamp = (s_lo > smooth_ceil) ? smooth_ceil : s_lo;

  assign div_radius = (res[DW-1:RW] != '0) ? RadiusMax : res[RW-1:0];
  assign cnt_wide   = 33'(point_count);

  assign item_stall   = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign result_valid = out_valid;
  assign result       = out_reg;

  wfbr_arith #(
    .DW(DW)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .opc  (opc),
    .done (arith_done),
    .res  (res)
  );

  // Operand select for the shared unit
  always_comb begin
    req.go = 1'b0;
    req.op = wfbr_pkg::ARITH_MAC;
    opa    = '0;
    opb    = '0;
    opc    = '0;
    unique case (state)
      S_LIMSEG: begin
        req.go = !issued;
        opa    = DW'(min_seg);
        opb    = DW'(min_seg);
      end
      S_DIFF: begin
        // d = p - last, then ne = last - p
        req.go = !issued;
        opb    = {DW{1'b1}};
        if (!j) begin
          opa = sx_coord(last_pt[k]);
          opc = sx_coord(p[k]);
        end else begin
          opa = sx_coord(p[k]);
          opc = sx_coord(last_pt[k]);
        end
      end
      S_DSQ: begin
        req.go = !issued;
        opa    = sx_diff(d_vec[k]);
        opb    = sx_diff(d_vec[k]);
        opc    = (k == 2'd0) ? '0 : res;
      end
      S_CROSS: begin
        req.go = !issued;
        if (!j) begin
          opa = sx_diff(a_vec[k1]);
          opb = sx_diff(d_vec[k2]);
        end else begin
          opa = sx_diff(a_vec[k2]);
          opb = sx_diff(ne_vec[k1]);
          opc = res;
        end
      end
      S_CSQ: begin
        req.go = !issued;
        opa    = sx_sq(c_vec[k]);
        opb    = sx_sq(c_vec[k]);
        opc    = (k == 2'd0) ? '0 : res;
      end
      S_LIMCOL: begin
        req.go = !issued;
        opa    = DW'(min_col);
        opb    = DW'(min_col);
      end
      S_AB: begin
        req.go = !issued;
        opa    = DW'(d1);
        opb    = DW'(dsq);
      end
      S_ABSQ: begin
        req.go = !issued;
        req.op = wfbr_pkg::ARITH_SQRT;
        opa    = res;
      end
      S_DOT: begin
        req.go = !issued;
        opa    = sx_diff(a_vec[k]);
        opb    = sx_diff(d_vec[k]);
        opc    = (k == 2'd0) ? '0 : res;
      end
      S_TN: begin
        req.go = !issued;
        opa    = sx_sq(dot_ae);
        opb    = DW'(1);
        opc    = DW'(ab);
      end
      S_CN: begin
        req.go = !issued;
        req.op = wfbr_pkg::ARITH_SQRT;
        opa    = DW'(csq);
      end
      S_M: begin
        req.go = !issued;
        req.op = wfbr_pkg::ARITH_SQRT;
        opa    = (d1 < dsq) ? DW'(d1) : DW'(dsq);
      end
      S_NUM: begin
        req.go = !issued;
        opa    = DW'(m);
        opb    = DW'(tn);
      end
      S_DIV: begin
        req.go = !issued;
        req.op = wfbr_pkg::ARITH_DIV;
        opa    = res;
        opb    = DW'({cn, 1'b0});
      end
      S_FSCALE: begin
        req.go = !issued;
        opa    = DW'(min_radius);
        opb    = DW'(s_clamp);
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seg      <= wfbr_pkg::MinSegmentRst;
      min_col      <= wfbr_pkg::MinColinearRst;
      smooth       <= wfbr_pkg::SmoothnessRst;
      smooth_floor <= wfbr_pkg::SmoothFloorRst;
      smooth_ceil  <= wfbr_pkg::SmoothCeilRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wfbr_pkg::CfgMinSegment:  min_seg      <= cfg_data[wfbr_pkg::SegWidth-1:0];
        wfbr_pkg::CfgMinColinear: min_col      <= cfg_data[wfbr_pkg::NormWidth-1:0];
        wfbr_pkg::CfgSmoothness:  smooth       <= cfg_data[wfbr_pkg::SmoothWidth-1:0];
        wfbr_pkg::CfgSmoothFloor: smooth_floor <= cfg_data[wfbr_pkg::SmoothWidth-1:0];
        wfbr_pkg::CfgSmoothCeil:  smooth_ceil  <= cfg_data[wfbr_pkg::SmoothWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and path state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      issued      <= 1'b0;
      k           <= 2'd0;
      j           <= 1'b0;
      point_count <= '0;
      min_radius  <= RadiusMax;
      error_flag  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (req.go) begin
        issued <= 1'b1;
      end
      if (arith_done) begin
        issued <= 1'b0;
      end
      // drop the result once taken; a new load below overrides
      if (out_valid && !result_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid && !item_stall) begin
            p      <= item_p;
            p_last <= item.is_last;
            k      <= 2'd0;
            j      <= 1'b0;
            if (item.is_start || point_count == '0) begin
              // start pose: reset the running state
              last_pt     <= item_p;
              point_count <= COUNT_WIDTH'(1);
              min_radius  <= RadiusMax;
              error_flag  <= 1'b0;
              kept        <= 1'b1;
              state       <= S_FIN;
            end else begin
              kept  <= 1'b0;
              state <= S_LIMSEG;
            end
          end
        end
        S_LIMSEG: begin
          if (arith_done) begin
            lim_seg <= res[31:0];
            state   <= S_DIFF;
          end
        end
        S_DIFF: begin
          if (arith_done) begin
            if (!j) begin
              d_vec[k] <= res[DFW-1:0];
              j        <= 1'b1;
            end else begin
              ne_vec[k] <= res[DFW-1:0];
              j         <= 1'b0;
              if (k == 2'd2) begin
                k     <= 2'd0;
                state <= S_DSQ;
              end else begin
                k <= k + 2'd1;
              end
            end
          end
        end
        S_DSQ: begin
          if (arith_done) begin
            if (k == 2'd2) begin
              dsq   <= res[SQW-1:0];
              k     <= 2'd0;
              state <= S_KEEP;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_KEEP: begin
          if (dsq > SQW'(lim_seg)) begin
            kept <= 1'b1;
            if (point_count >= COUNT_WIDTH'(2)) begin
              state <= S_CROSS;
            end else begin
              state <= S_COMMIT;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_CROSS: begin
          if (arith_done) begin
            if (!j) begin
              j <= 1'b1;
            end else begin
              c_vec[k] <= res[SQW-1:0];
              j        <= 1'b0;
              if (k == 2'd2) begin
                k     <= 2'd0;
                state <= S_CSQ;
              end else begin
                k <= k + 2'd1;
              end
            end
          end
        end
        S_CSQ: begin
          if (arith_done) begin
            if (k == 2'd2) begin
              csq   <= res[QW-1:0];
              k     <= 2'd0;
              state <= S_LIMCOL;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_LIMCOL: begin
          if (arith_done) begin
            lim_col <= res[63:0];
            state   <= S_COLCHK;
          end
        end
        S_COLCHK: begin
          // colinear junction: flag it and add no radius
          if (csq < QW'(lim_col)) begin
            error_flag <= 1'b1;
            state      <= S_COMMIT;
          end else if (d1 < SQW'(lim_seg) || dsq < SQW'(lim_seg)) begin
            state <= S_COMMIT;
          end else begin
            state <= S_AB;
          end
        end
        S_AB: begin
          if (arith_done) begin
            state <= S_ABSQ;
          end
        end
        S_ABSQ: begin
          if (arith_done) begin
            ab    <= res[SQW-1:0];
            k     <= 2'd0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          if (arith_done) begin
            if (k == 2'd2) begin
              dot_ae <= res[SQW-1:0];
              k      <= 2'd0;
              state  <= S_TN;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        S_TN: begin
          if (arith_done) begin
            tn    <= res[SQW-1:0];
            state <= S_CN;
          end
        end
        S_CN: begin
          if (arith_done) begin
            cn    <= res[SQW-1:0];
            state <= S_CNCHK;
          end
        end
        S_CNCHK: begin
          // zero cross norm: straight-back turn limits to zero, else no limit
          if (cn == '0) begin
            if (tn == '0) begin
              min_radius <= '0;
            end
            state <= S_COMMIT;
          end else begin
            state <= S_M;
          end
        end
        S_M: begin
          if (arith_done) begin
            m     <= res[MW-1:0];
            state <= S_NUM;
          end
        end
        S_NUM: begin
          if (arith_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (arith_done) begin
            if (div_radius < min_radius) begin
              min_radius <= div_radius;
            end
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          a_vec   <= d_vec;
          d1      <= dsq;
          last_pt <= p;
          if (point_count != {COUNT_WIDTH{1'b1}}) begin
            point_count <= point_count + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          fin_radius <= RadiusMax;
          if (p_last && min_radius != RadiusMax) begin
            state <= S_FSCALE;
          end else begin
            state <= S_OUT;
          end
        end
        S_FSCALE: begin
          if (arith_done) begin
            fin_radius <= (res[DW-1:RW+16] != '0) ? RadiusMax : res[RW+15:16];
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid || !result_stall) begin
            out_reg.kept           <= kept;
            out_reg.is_final       <= p_last;
            out_reg.blend_radius   <= p_last ? fin_radius : '0;
            out_reg.colinear_error <= p_last & error_flag;
            out_reg.kept_count     <= !p_last ? '0 :
                                      (cnt_wide > 33'd65535) ? 16'hFFFF : cnt_wide[15:0];
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/wfbr_arith.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared iterative arithmetic unit
// Multiply-accumulate (radix-256), integer square root and restoring division,
// all built around one add/subtract unit.
// ----------------------------------------------------------------------------
module wfbr_arith #(
  parameter int DW = wfbr_pkg::DataWidthDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wfbr_pkg::arith_req_t req,
  input  logic [DW-1:0]        opa,
  input  logic [DW-1:0]        opb,
  input  logic [DW-1:0]        opc,
  output logic                 done,
  output logic [DW-1:0]        res
);

  localparam int CntW = $clog2(DW + 1);
  localparam int DigW = wfbr_pkg::DigitWidth;

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_FIN  = 5'b00100,
    U_SQRT = 5'b01000,
    U_DIV  = 5'b10000
  } ustate_t;

  ustate_t state;
  logic [DW-1:0] xr, yr, pr, cr;
  logic [CntW-1:0] cnt;
  logic y_zero, y_ones;
  logic [DW+DigW-1:0] prod_full;
  logic [DW-1:0] add_a, add_b, sq_rem, sq_trial, dv_rem;
  logic add_sub, add_carry;
  logic [DW:0] add_sum;

  assign y_zero    = (yr == '0);
  assign y_ones    = &yr;
  assign prod_full = xr * yr[DigW-1:0];
  assign sq_rem    = {pr[DW-3:0], xr[DW-1:DW-2]};
  assign sq_trial  = {yr[DW-3:0], 2'b01};
  assign dv_rem    = {pr[DW-2:0], xr[DW-1]};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      U_MUL: begin
        add_a   = pr;
        add_b   = y_ones ? xr : prod_full[DW-1:0];
        add_sub = y_ones;
      end
      U_FIN: begin
        add_a = cr;
        add_b = pr;
      end
      U_SQRT: begin
        add_a   = sq_rem;
        add_b   = sq_trial;
        add_sub = 1'b1;
      end
      U_DIV: begin
        add_a   = dv_rem;
        add_b   = yr;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{DW{1'b0}}, add_sub};
  assign add_carry = add_sum[DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (req.go) begin
            unique case (req.op)
              wfbr_pkg::ARITH_MAC: begin
                xr    <= opa;
                yr    <= opb;
                pr    <= '0;
                cr    <= opc;
                state <= U_MUL;
              end
              wfbr_pkg::ARITH_SQRT: begin
                xr    <= opa;
                yr    <= '0;
                pr    <= '0;
                cnt   <= CntW'(DW / 2);
                state <= U_SQRT;
              end
              wfbr_pkg::ARITH_DIV: begin
                xr    <= opa;
                yr    <= opb;
                pr    <= '0;
                cr    <= '0;
                cnt   <= CntW'(DW);
                state <= U_DIV;
              end
              default: begin
              end
            endcase
          end
        end
        U_MUL: begin
          // stop once the rest of the multiplier is all zeros or all ones
          if (y_zero) begin
            state <= U_FIN;
          end else begin
            pr <= add_sum[DW-1:0];
            if (y_ones) begin
              state <= U_FIN;
            end else begin
              xr <= xr << DigW;
              yr <= $signed(yr) >>> DigW;
            end
          end
        end
        U_FIN: begin
          res   <= add_sum[DW-1:0];
          done  <= 1'b1;
          state <= U_IDLE;
        end
        U_SQRT: begin
          xr  <= xr << 2;
          pr  <= add_carry ? add_sum[DW-1:0] : sq_rem;
          yr  <= {yr[DW-2:0], add_carry};
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            res   <= {yr[DW-2:0], add_carry};
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        U_DIV: begin
          xr  <= xr << 1;
          pr  <= add_carry ? add_sum[DW-1:0] : dv_rem;
          cr  <= {cr[DW-2:0], add_carry};
          cnt <= cnt - 1'b1;
          if (cnt == CntW'(1)) begin
            res   <= {cr[DW-2:0], add_carry};
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waypoint filter / blend radius core testbench
// Sends short waypoint lists and random noise through the core under several
// register settings. A bit-exact predictor computes the kept flag, the colinear
// flag and the scaled blend radius, and every result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import wfbr_pkg::*;

  typedef logic signed [191:0] wide_t;

  localparam int HalfPeriod   = 6;
  localparam int StallLimit   = 6000;
  localparam int ItemsTarget  = 1650;
  localparam int NumPhases    = 6;
  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  waypoint_filter_blend_radius_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(HalfPeriod) clk = ~clk;

  // Path state and register copies of the predictor
  logic signed [31:0] last_pt[3];
  logic signed [31:0] prior_pt[3];
  int unsigned        path_count;
  logic [31:0]        min_blend;
  logic               colinear_seen;
  logic [15:0]        seg_len;
  logic [31:0]        colinear_norm;
  logic [16:0]        smooth, smooth_lo, smooth_hi;

  result_t pending_results[$];
  int  errors = 0;
  int  checked = 0;
  int  finals_seen = 0;
  int  colinear_reports = 0;
  int  junctions_done = 0;
  int  items_sent = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  // Floor of the square root; every operand stays below 2^140
  function automatic wide_t isqrt(wide_t x);
    wide_t root, cand;
    root = '0;
    for (int i = 79; i >= 0; i--) begin
      cand = root | (wide_t'(1) <<< i);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  // Update the smallest blend radius with the junction prior -> last -> p
  function automatic void update_junction(logic signed [31:0] p[3]);
    wide_t a[3], e[3], c[3];
    wide_t csq, d1, d2, lim, ab, dotp, tn, cn, m, q;
    logic [31:0] r;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'(last_pt[i]) - wide_t'(prior_pt[i]);
      e[i] = wide_t'(p[i]) - wide_t'(last_pt[i]);
    end
    c[0] = a[1] * e[2] - a[2] * e[1];
    c[1] = a[2] * e[0] - a[0] * e[2];
    c[2] = a[0] * e[1] - a[1] * e[0];
    csq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    lim = wide_t'({32'd0, colinear_norm}) * wide_t'({32'd0, colinear_norm});
    if (csq < lim) begin
      colinear_seen = 1'b1;
      return;
    end
    d1 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    d2 = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
    lim = wide_t'({16'd0, seg_len}) * wide_t'({16'd0, seg_len});
    if (d1 < lim || d2 < lim) return;
    junctions_done++;
    ab = isqrt(d1 * d2);
    // b = -e, so a.b is minus a.e
    dotp = -(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    tn = ab - dotp;
    cn = isqrt(csq);
    if (cn == 0) begin
      if (tn == 0) min_blend = '0;
      return;
    end
    m = isqrt(d1 < d2 ? d1 : d2);
    q = (m * tn) / (cn + cn);
    r = (q > wide_t'({1'b0, AllOnes})) ? AllOnes : q[31:0];
    if (r < min_blend) min_blend = r;
  endfunction

  function automatic result_t predict_waypoint(item_t it);
    logic signed [31:0] p[3];
    wide_t dsq, lim, d;
    logic [16:0] s;
    logic [48:0] scaled;
    result_t res;
    p[0] = it.pos_x;
    p[1] = it.pos_y;
    p[2] = it.pos_z;
    res = '0;
    if (it.is_start || path_count == 0) begin
      last_pt = p;
      path_count = 1;
      min_blend = AllOnes;
      colinear_seen = 1'b0;
      res.kept = 1'b1;
    end else begin
      dsq = '0;
      for (int i = 0; i < 3; i++) begin
        d = wide_t'(p[i]) - wide_t'(last_pt[i]);
        dsq += d * d;
      end
      lim = wide_t'({16'd0, seg_len}) * wide_t'({16'd0, seg_len});
      if (dsq > lim) begin
        res.kept = 1'b1;
        if (path_count >= 2) update_junction(p);
        prior_pt = last_pt;
        last_pt = p;
        if (path_count < 65535) path_count++;
      end
    end
    if (it.is_last) begin
      s = smooth;
      if (s < smooth_lo) s = smooth_lo;
      if (s > smooth_hi) s = smooth_hi;
      res.is_final = 1'b1;
      res.blend_radius = AllOnes;
      if (min_blend != AllOnes) begin
        scaled = ({17'd0, min_blend} * {32'd0, s}) >> 16;
        res.blend_radius = (scaled > {17'd0, AllOnes}) ? AllOnes : scaled[31:0];
      end
      res.colinear_error = colinear_seen;
      res.kept_count = path_count[15:0];
    end
    return res;
  endfunction

  function automatic item_t make_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic st, logic la);
    item_t it;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.is_start = st;
    it.is_last = la;
    return it;
  endfunction

  // Offer one transaction and hold it until the core takes it
  task automatic send_waypoint(item_t it, bit typed, result_t typed_res);
    result_t predicted;
    if (!no_idle && $urandom_range(99) < 19) begin
      @(negedge clk);
      item_valid <= 1'b0;
      item <= make_item($urandom, $urandom, $urandom, $urandom, $urandom);
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    predicted = predict_waypoint(it);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    item_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgMinSegment:  seg_len = val[15:0];
      CfgMinColinear: colinear_norm = val;
      CfgSmoothness:  smooth = val[16:0];
      CfgSmoothFloor: smooth_lo = val[16:0];
      CfgSmoothCeil:  smooth_hi = val[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Pick the next coordinate from the current path, biased toward the
  // drop boundary, colinear runs and full-range jumps
  function automatic logic [31:0] next_coord(int axis, int mode, int k);
    logic signed [31:0] lp, pp;
    int span;
    lp = last_pt[axis];
    pp = prior_pt[axis];
    span = (seg_len == 0) ? 4 : 2 * seg_len;
    case (mode)
      0: return lp + $signed($urandom_range(2 * span)) - span;
      1: return lp + $signed($urandom_range(20000)) - 10000;
      2: return lp + k * (lp - pp);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_list();
    int len, mode, k;
    item_t it;
    result_t none;
    none = '0;
    if ($urandom_range(99) < 15) begin
      // noise: random flags and coordinates anywhere
      it = make_item($urandom, $urandom, $urandom, $urandom, $urandom);
      send_waypoint(it, 1'b0, none);
      return;
    end
    len = $urandom_range(8, 2);
    for (int n = 0; n < len; n++) begin
      mode = $urandom_range(99) < 30 ? 0 : $urandom_range(99) < 50 ? 1 :
             $urandom_range(99) < 60 ? 2 : 3;
      k = ($urandom_range(1) ? 1 : -1) * $urandom_range(3, 1);
      it = make_item(next_coord(0, mode, k), next_coord(1, mode, k),
                     next_coord(2, mode, k),
                     n == 0 && $urandom_range(9) != 0, n == len - 1);
      send_waypoint(it, 1'b0, none);
    end
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) hold_left = 500;
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !no_idle && ($urandom_range(99) < 19);
    end
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (want.is_final) finals_seen++;
        if (want.colinear_error) colinear_reports++;
        if (result.kept !== want.kept)
          $display("%0t: kept exp %0d got %0d", $time, want.kept, result.kept);
        if (result.is_final !== want.is_final)
          $display("%0t: is_final exp %0d got %0d", $time, want.is_final, result.is_final);
        if (result.blend_radius !== want.blend_radius)
          $display("%0t: blend_radius exp %0d got %0d", $time,
                   want.blend_radius, result.blend_radius);
        if (result.colinear_error !== want.colinear_error)
          $display("%0t: colinear_error exp %0d got %0d", $time,
                   want.colinear_error, result.colinear_error);
        if (result.kept_count !== want.kept_count)
          $display("%0t: kept_count exp %0d got %0d", $time,
                   want.kept_count, result.kept_count);
        if (result !== want) errors++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout after %0d idle cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic void add_row(item_t it, bit typed, result_t res);
    stim_row_t r;
    r.it = it;
    r.typed = typed;
    r.res = res;
    rows.push_back(r);
  endfunction

  function automatic result_t typed_result(logic k, logic f, logic [31:0] rad,
                                           logic ce, logic [15:0] cnt);
    result_t r;
    r.kept = k;
    r.is_final = f;
    r.blend_radius = rad;
    r.colinear_error = ce;
    r.kept_count = cnt;
    return r;
  endfunction

  logic [31:0] phase_cfg[NumPhases][5] = '{
    '{32'd10,    32'd1,          32'd65536, 32'd0,     32'd65536},
    '{32'd0,     32'd0,          32'd32768, 32'd0,     32'd65536},
    '{32'd65535, 32'hFFFF_FFFF,  32'd0,     32'd0,     32'd65536},
    '{32'd100,   32'd1000,       32'd40000, 32'd50000, 32'd65536},
    '{32'd20,    32'd10,         32'd60000, 32'd65536, 32'd30000},
    '{32'd3,     32'd0,          32'd1,     32'd0,     32'd1}
  };

  initial begin
    result_t none;
    int phase_target;
    none = '0;
    last_pt = '{default: '0};
    prior_pt = '{default: '0};
    path_count = 0;
    min_blend = AllOnes;
    colinear_seen = 1'b0;
    seg_len = MinSegmentRst;
    colinear_norm = MinColinearRst;
    smooth = SmoothnessRst;
    smooth_lo = SmoothFloorRst;
    smooth_hi = SmoothCeilRst;

    // no start seen yet: a plain point opens the list
    add_row(make_item(32'd0, 32'd0, 32'd0, 1'b0, 1'b0), 1'b1, typed_result(1, 0, 0, 0, 0));
    // start and last together at the positive extreme
    add_row(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1), 1'b1,
            typed_result(1, 1, AllOnes, 0, 1));
    add_row(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0), 1'b1,
            typed_result(1, 0, 0, 0, 0));
    // too close to keep, then the far corner
    add_row(make_item(32'h8000_0005, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1), 1'b0, none);
    // last item without a new start continues the path
    add_row(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1), 1'b0, none);
    // right angle, straight run (colinear) and full reversal
    add_row(make_item(32'd0, 32'd0, 32'd0, 1'b1, 1'b0), 1'b1, typed_result(1, 0, 0, 0, 0));
    add_row(make_item(32'd1000, 32'd0, 32'd0, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'd1000, 32'd1000, 32'd0, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'd1000, 32'd2000, 32'd0, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'd1000, 32'd500, 32'd0, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'd1010, 32'd500, 32'd0, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'd1011, 32'd500, 32'd0, 1'b0, 1'b0), 1'b0, none);
    add_row(make_item(32'hFFFF_F000, 32'd7, 32'd300, 1'b0, 1'b1), 1'b0, none);
    add_row(make_item(32'd5, 32'd5, 32'd5, 1'b1, 1'b1), 1'b1, typed_result(1, 1, AllOnes, 0, 1));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_waypoint(rows[i].it, rows[i].typed, rows[i].res);
    drop_valid();

    for (int ph = 0; ph < NumPhases; ph++) begin
      // hold the sender until the core is empty before touching registers
      wait_drained();
      for (int r = 0; r < 5; r++) write_reg(r[CfgIndexWidth-1:0], phase_cfg[ph][r]);
      no_idle = (ph == 1);
      phase_target = items_sent + ItemsTarget / NumPhases;
      while (items_sent < phase_target) begin
        if (ph == 2 && items_sent + 150 == phase_target) begin
          // long receiver hold-off while items keep coming
          hold_req = 1'b1;
          send_random_list();
          hold_req = 1'b0;
        end else if (ph == 3 && items_sent + 100 >= phase_target && items_sent + 95 < phase_target) begin
          drop_valid();
          wait_drained();
          send_random_list();
        end else begin
          send_random_list();
        end
      end
      drop_valid();
    end

    wait_drained();
    repeat (700) @(posedge clk);
    $display("checked %0d results (%0d final reports, %0d colinear) over %0d settings,",
             checked, finals_seen, colinear_reports, NumPhases);
    $display("%0d junction radii evaluated from %0d waypoints", junctions_done, items_sent);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wfbr_pkg.sv
src/wfbr_arith.sv
src/waypoint_filter_blend_radius_core.sv
tb/testbench.sv
